@@ sv/bgrc_pkg.sv @@
// bgrc_pkg: shared types, constants and scaling functions of the battery gauge reading conditioner
// no dependencies; imported by the interfaces, bgrc_step and the top level
`default_nettype none

package bgrc_pkg;

  localparam int unsigned MV_W       = 13;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned HELD_PCT_W = 7;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned SOC_W      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTORY_NO_BATT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOC_OVR_ENABLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOC_OVR_VALUE   = 2'd3;

  localparam logic OP_VOLTAGE  = 1'b0;
  localparam logic OP_CAPACITY = 1'b1;

  localparam logic [MV_W-1:0]       HELD_MV_RESET  = 13'd4200;
  localparam logic [HELD_PCT_W-1:0] HELD_PCT_RESET = 7'd100;
  localparam logic [PCT_W-1:0]      SOC_OVR_RESET  = 8'd255;
  localparam logic [PCT_W-1:0]      FACTORY_PCT    = 8'd70;
  localparam logic [HELD_PCT_W-1:0] PCT_MAX        = 7'd100;
  localparam logic [HELD_PCT_W-1:0] PCT_MIN_LIVE   = 7'd1;
  localparam logic [SOC_W-1:0]      SOC_BUMP_ABOVE = 9'd74;

  localparam logic [MV_W-1:0] FACTORY_MV_T0 = 13'd4350;
  localparam logic [MV_W-1:0] FACTORY_MV_T1 = 13'd4200;
  localparam logic [MV_W-1:0] FLOOR_MV_T0   = 13'd3500;
  localparam logic [MV_W-1:0] FLOOR_MV_T1   = 13'd3400;

  // floor(x/9) = (x*RECIP_9) >> 16 for x below 2551
  localparam logic [12:0] RECIP_9  = 13'd7282;
  // floor(w*3906/900000) = (w*RECIP_T1) >> 40 for any 16-bit w
  localparam logic [32:0] RECIP_T1 = 33'd4771880465;

  typedef struct packed {
    logic       op;
    logic [7:0] vcell_high;
    logic [7:0] vcell_low;
    logic       vcell_ok;
    logic [7:0] charge_high;
    logic [7:0] charge_low;
    logic       charge_ok;
    logic       charger_present;
  } bgrc_in_t;

  typedef struct packed {
    logic [MV_W-1:0]  millivolts;
    logic [PCT_W-1:0] percent;
  } bgrc_out_t;

  typedef struct packed {
    logic             battery_type;
    logic             factory_no_battery;
    logic             soc_override_enable;
    logic [PCT_W-1:0] soc_override_value;
  } bgrc_cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]       held_mv;
    logic [HELD_PCT_W-1:0] held_pct;
  } bgrc_state_t;

  // code * 125 / 100 == code * 5 / 4
  function automatic logic [MV_W-1:0] code_to_mv(input logic [7:0] hi, input logic [7:0] lo);
    logic [CODE_W-1:0] code;
    logic [14:0]       x5;
    code = {hi, lo[7:4]};
    x5   = {1'b0, code, 2'b00} + {3'b000, code};
    return x5[14:2];
  endfunction

  function automatic logic [HELD_PCT_W-1:0] clamp_soc(input logic [SOC_W-1:0] q);
    return (q > SOC_W'(PCT_MAX)) ? PCT_MAX : q[HELD_PCT_W-1:0];
  endfunction

  function automatic logic [HELD_PCT_W-1:0] soc_type0(input logic [7:0] ch);
    logic [11:0]      x;
    logic [24:0]      prod;
    logic [SOC_W-1:0] q;
    x    = {1'b0, ch, 3'b000} + {3'b000, ch, 1'b0};
    prod = 25'(x) * 25'(RECIP_9);
    q    = prod[24:16];
    if (q > SOC_BUMP_ABOVE) begin
      q = q + 9'd1;
    end
    return clamp_soc(q);
  endfunction

  function automatic logic [HELD_PCT_W-1:0] soc_type1(input logic [7:0] ch,
                                                      input logic [7:0] cl);
    logic [15:0] w;
    logic [48:0] prod;
    w    = {ch, cl};
    prod = 49'(w) * 49'(RECIP_T1);
    return clamp_soc(prod[48:40]);
  endfunction

endpackage

`default_nettype wire

@@ sv/bgrc_in_if.sv @@
// bgrc_in_if: valid/ready channel carrying one query beat
// depends on bgrc_pkg for the payload type
`default_nettype none

interface bgrc_in_if
  import bgrc_pkg::*;
();
  logic     valid;
  logic     ready;
  bgrc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bgrc_out_if.sv @@
// bgrc_out_if: valid/ready channel carrying one result beat
// depends on bgrc_pkg for the payload type
`default_nettype none

interface bgrc_out_if
  import bgrc_pkg::*;
();
  logic      valid;
  logic      ready;
  bgrc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bgrc_step.sv @@
// bgrc_step: combinational evaluation of one query against the held voltage and capacity
// depends on bgrc_pkg
`default_nettype none

module bgrc_step
  import bgrc_pkg::*;
(
  input  bgrc_in_t    item,
  input  bgrc_cfg_t   cfg,
  input  bgrc_state_t state,
  output bgrc_state_t state_next,
  output bgrc_out_t   result
);

  logic [MV_W-1:0]       mv_read;
  logic [MV_W-1:0]       mv_eval;
  logic [MV_W-1:0]       floor_mv;
  logic [HELD_PCT_W-1:0] soc_raw;
  logic [HELD_PCT_W-1:0] soc_floor;
  logic [HELD_PCT_W-1:0] soc_min;

  always_comb begin
    mv_read = code_to_mv(item.vcell_high, item.vcell_low);
    if (!item.vcell_ok) begin
      mv_eval = state.held_mv;
    end else if (!item.charger_present && (state.held_mv < mv_read)) begin
      mv_eval = state.held_mv;
    end else begin
      mv_eval = mv_read;
    end

    floor_mv  = cfg.battery_type ? FLOOR_MV_T1 : FLOOR_MV_T0;
    soc_raw   = cfg.battery_type ? soc_type1(item.charge_high, item.charge_low)
                                 : soc_type0(item.charge_high);
    soc_floor = ((soc_raw == '0) && (mv_eval > floor_mv)) ? PCT_MIN_LIVE : soc_raw;
    soc_min   = (!item.charger_present && (state.held_pct < soc_floor)) ? state.held_pct
                                                                         : soc_floor;

    state_next = state;
    result     = '0;
    case (item.op)
      OP_VOLTAGE: begin
        if (cfg.factory_no_battery) begin
          result.millivolts = cfg.battery_type ? FACTORY_MV_T1 : FACTORY_MV_T0;
        end else begin
          state_next.held_mv = mv_eval;
          result.millivolts  = mv_eval;
        end
        result.percent = PCT_W'(state.held_pct);
      end
      OP_CAPACITY: begin
        if (cfg.soc_override_enable) begin
          result.percent = cfg.soc_override_value;
        end else if (cfg.factory_no_battery) begin
          result.percent = FACTORY_PCT;
        end else if (!item.charge_ok) begin
          result.percent = PCT_W'(state.held_pct);
        end else begin
          state_next.held_mv = mv_eval;
          if (cfg.battery_type) begin
            state_next.held_pct = soc_min;
            result.percent      = PCT_W'(soc_min);
          end else begin
            result.percent = PCT_W'(soc_floor);
          end
        end
        result.millivolts = state_next.held_mv;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/battery_gauge_reading_conditioner.sv @@
// battery_gauge_reading_conditioner: top level, input register, held state and result register
// depends on bgrc_pkg, bgrc_in_if, bgrc_out_if and bgrc_step
//
//   channel   dir  beat payload
//   reading   in   op, vcell bytes and ok, charge bytes and ok, charger_present
//   result    out  millivolts, percent
//   cfg_*     in   write enable, 2-bit register index, 8-bit data
//
// one query per cycle sustained unless result stalls; via the input, then the result register
// the held voltage and capacity update when a query moves into the result register
// synchronous reset restores valid flags, configuration and held state, no clearing pass
// a stalled result holds its register; one more query waits in the input register
`default_nettype none

module battery_gauge_reading_conditioner
  import bgrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bgrc_in_if.sink                    reading,
  bgrc_out_if.source                 result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bgrc_cfg_t   cfg;
  bgrc_state_t state;
  bgrc_state_t state_next;
  logic        s1_valid;
  bgrc_in_t    s1_item;
  logic        out_valid;
  bgrc_out_t   out_data;
  bgrc_out_t   step_result;
  logic        advance;

  assign advance       = s1_valid && (!out_valid || result.ready);
  assign reading.ready = !s1_valid || advance;
  assign result.valid  = out_valid;
  assign result.data   = out_data;

  bgrc_step u_step (
    .item       (s1_item),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_type        <= 1'b0;
      cfg.factory_no_battery  <= 1'b0;
      cfg.soc_override_enable <= 1'b0;
      cfg.soc_override_value  <= SOC_OVR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BATTERY_TYPE:    cfg.battery_type        <= cfg_data[0];
        REG_FACTORY_NO_BATT: cfg.factory_no_battery  <= cfg_data[0];
        REG_SOC_OVR_ENABLE:  cfg.soc_override_enable <= cfg_data[0];
        REG_SOC_OVR_VALUE:   cfg.soc_override_value  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      state.held_mv  <= HELD_MV_RESET;
      state.held_pct <= HELD_PCT_RESET;
    end else begin
      if (reading.valid && reading.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reading.valid && reading.ready) begin
      s1_item <= reading.data;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

`ifndef SYNTHESIS
  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |=> s1_valid && $stable(s1_item))
    else $error("queued query lost while result stalled");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("held state changed without a query moving");

  a_held_pct_range: assert property (@(posedge clk) disable iff (rst)
    state.held_pct <= PCT_MAX)
    else $error("held capacity above full scale");

  a_held_mv_range: assert property (@(posedge clk) disable iff (rst)
    state.held_mv <= 13'd5118)
    else $error("held voltage above conversion range");
`endif

endmodule

`default_nettype wire

@@ tb/sv/battery_gauge_reading_conditioner_test.sv @@
// battery_gauge_reading_conditioner_test: self-checking bench with query stimulus, result checks
// and register writes between phases
// depends on bgrc_pkg, bgrc_in_if, bgrc_out_if and battery_gauge_reading_conditioner
`default_nettype none

module battery_gauge_reading_conditioner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bgrc_pkg::*;

  class gauge_scoreboard;
    bgrc_cfg_t             cfg;
    logic [MV_W-1:0]       held_mv;
    logic [HELD_PCT_W-1:0] held_pct;
    bgrc_out_t             owed_readings[$];
    int                    errors;

    function new();
      cfg = '{battery_type: 1'b0, factory_no_battery: 1'b0, soc_override_enable: 1'b0,
              soc_override_value: SOC_OVR_RESET};
      held_mv  = HELD_MV_RESET;
      held_pct = HELD_PCT_RESET;
      errors   = 0;
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    // min-hold while discharging, follow while charging, keep on failed read
    function logic [MV_W-1:0] sense_voltage(bgrc_in_t q);
      int unsigned code;
      int unsigned mv;
      if (!q.vcell_ok) begin
        return held_mv;
      end
      code = 32'({q.vcell_high, q.vcell_low[7:4]});
      mv   = code * 125 / 100;
      if (!q.charger_present && held_mv < mv) begin
        mv = held_mv;
      end
      held_mv = MV_W'(mv);
      return held_mv;
    endfunction

    function bgrc_out_t condition_query(bgrc_in_t q);
      bgrc_out_t   r;
      int unsigned mv;
      int unsigned soc;
      int unsigned word;
      if (q.op == OP_VOLTAGE) begin
        if (cfg.factory_no_battery) begin
          r.millivolts = cfg.battery_type ? FACTORY_MV_T1 : FACTORY_MV_T0;
        end else begin
          r.millivolts = sense_voltage(q);
        end
        r.percent = PCT_W'(held_pct);
      end else begin
        if (cfg.soc_override_enable) begin
          r.percent = cfg.soc_override_value;
        end else if (cfg.factory_no_battery) begin
          r.percent = FACTORY_PCT;
        end else if (!q.charge_ok) begin
          r.percent = PCT_W'(held_pct);
        end else begin
          if (!cfg.battery_type) begin
            soc = 32'(q.charge_high);
            soc = soc * 100 / 90;
            if (soc > SOC_BUMP_ABOVE) begin
              soc = soc + 1;
            end
          end else begin
            word = 32'({q.charge_high, q.charge_low});
            soc  = word * 3906 / 90 / 10000;
          end
          if (soc > PCT_MAX) begin
            soc = 32'(PCT_MAX);
          end
          mv = 32'(sense_voltage(q));
          if (soc == 0 && mv > (cfg.battery_type ? FLOOR_MV_T1 : FLOOR_MV_T0)) begin
            soc = 1;
          end
          if (cfg.battery_type) begin
            if (!q.charger_present && held_pct < soc) begin
              soc = 32'(held_pct);
            end
            held_pct = HELD_PCT_W'(soc);
          end
          r.percent = PCT_W'(soc);
        end
        r.millivolts = held_mv;
      end
      return r;
    endfunction

    function void note_query(bgrc_in_t q);
      owed_readings.push_back(condition_query(q));
    endfunction

    function void check_result(bgrc_out_t got);
      bgrc_out_t want;
      if (owed_readings.size() == 0) begin
        $error("unexpected result beat: millivolts %0d percent %0d",
               got.millivolts, got.percent);
        errors++;
        return;
      end
      want = owed_readings.pop_front();
      if (got.millivolts !== want.millivolts) begin
        $error("millivolts: expected %0d, actual %0d", want.millivolts, got.millivolts);
        errors++;
      end
      if (got.percent !== want.percent) begin
        $error("percent: expected %0d, actual %0d", want.percent, got.percent);
        errors++;
      end
    endfunction
  endclass

  gauge_scoreboard sb;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int gap_pct;
  int stall_pct;
  bit plugged;

  bgrc_in_if  reading_ch ();
  bgrc_out_if result_ch ();

  battery_gauge_reading_conditioner DUT (
    .clk       (clk),
    .rst       (rst),
    .reading   (reading_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (reading_ch.valid && reading_ch.ready) begin
        sb.note_query(reading_ch.data);
      end
      if (result_ch.valid && result_ch.ready) begin
        sb.check_result(result_ch.data);
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result_ch.ready <= 1'b0;
        hold = $urandom_range(6, 0);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic bgrc_in_t query(logic op, logic [7:0] vh, logic [7:0] vl, logic vok,
                                     logic [7:0] ch, logic [7:0] cl, logic cok, logic chg);
    bgrc_in_t q;
    q.op              = op;
    q.vcell_high      = vh;
    q.vcell_low       = vl;
    q.vcell_ok        = vok;
    q.charge_high     = ch;
    q.charge_low      = cl;
    q.charge_ok       = cok;
    q.charger_present = chg;
    return q;
  endfunction

  // mostly plausible cell voltages around the floors, charger in stretches
  function automatic bgrc_in_t random_query();
    bgrc_in_t    q;
    int unsigned code;
    if ($urandom_range(7) == 0) begin
      plugged = !plugged;
    end
    if ($urandom_range(3) == 0) begin
      code = $urandom_range(4095);
    end else begin
      code = $urandom_range(3600, 2400);
    end
    q.op              = 1'($urandom_range(1));
    q.vcell_high      = code[11:4];
    q.vcell_low       = {code[3:0], 4'($urandom_range(15))};
    q.vcell_ok        = ($urandom_range(9) != 0);
    q.charge_high     = ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom_range(255));
    q.charge_low      = 8'($urandom_range(255));
    q.charge_ok       = ($urandom_range(9) != 0);
    q.charger_present = plugged;
    return q;
  endfunction

  task automatic send_query(input bgrc_in_t q);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      reading_ch.valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    reading_ch.valid <= 1'b1;
    reading_ch.data  <= q;
    do @(posedge clk); while (!reading_ch.ready);
  endtask

  task automatic drain();
    reading_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic apply_settings(input bgrc_cfg_t s);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BATTERY_TYPE;
    cfg_data  <= CFG_DATA_W'(s.battery_type);
    @(posedge clk);
    cfg_index <= REG_FACTORY_NO_BATT;
    cfg_data  <= CFG_DATA_W'(s.factory_no_battery);
    @(posedge clk);
    cfg_index <= REG_SOC_OVR_ENABLE;
    cfg_data  <= CFG_DATA_W'(s.soc_override_enable);
    @(posedge clk);
    cfg_index <= REG_SOC_OVR_VALUE;
    cfg_data  <= s.soc_override_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cfg = s;
  endtask

  initial begin
    bgrc_cfg_t setting;
    sb               = new();
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_BATTERY_TYPE;
    cfg_data         = '0;
    reading_ch.valid = 1'b0;
    reading_ch.data  = '0;
    gap_pct          = 30;
    stall_pct        = 30;
    plugged          = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // type 0, live readings
    send_query(query(OP_VOLTAGE, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_VOLTAGE, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 1'b0, 1'b1));
    send_query(query(OP_VOLTAGE, 8'hD0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_VOLTAGE, 8'hFF, 8'hF0, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0));
    send_query(query(OP_VOLTAGE, 8'hE0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b0));
    send_query(query(OP_VOLTAGE, 8'hC0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b0));
    // empty soc above, at and below the floor
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hAF, 8'h00, 1'b1, 8'h00, 8'hFF, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'h50, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    // bump threshold and clamp
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'd67, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'd68, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'd90, 8'h00, 1'b1, 1'b0));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'hFF, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'h40, 8'h00, 1'b0, 1'b1));

    // type 1 scaling and capacity min-hold
    setting = '{battery_type: 1'b1, factory_no_battery: 1'b0, soc_override_enable: 1'b0,
                soc_override_value: 8'd255};
    apply_settings(setting);
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hAA, 8'h00, 1'b1, 8'h00, 8'hE6, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'h40, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hD0, 8'h00, 1'b1, 8'h60, 8'h00, 1'b1, 1'b0));
    send_query(query(OP_VOLTAGE, 8'hC8, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));

    // factory mode, then override taking precedence
    setting.factory_no_battery = 1'b1;
    apply_settings(setting);
    send_query(query(OP_VOLTAGE, 8'h10, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'h10, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 1'b0));
    setting = '{battery_type: 1'b0, factory_no_battery: 1'b1, soc_override_enable: 1'b1,
                soc_override_value: 8'd0};
    apply_settings(setting);
    send_query(query(OP_VOLTAGE, 8'hFF, 8'hF0, 1'b1, 8'h00, 8'h00, 1'b1, 1'b1));
    send_query(query(OP_CAPACITY, 8'hFF, 8'hF0, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        setting = '0;
      end else if (ph == 1) begin
        setting = '1;
      end else begin
        setting.battery_type        = 1'($urandom_range(1));
        setting.factory_no_battery  = ($urandom_range(3) == 0);
        setting.soc_override_enable = ($urandom_range(3) == 0);
        setting.soc_override_value  = 8'($urandom_range(255));
      end
      apply_settings(setting);
      if (ph == 7) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 25 * $urandom_range(2);
        stall_pct = 25 * $urandom_range(2);
      end
      repeat (200) send_query(random_query());
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/bgrc_pkg.sv
sv/bgrc_in_if.sv
sv/bgrc_out_if.sv
sv/bgrc_step.sv
sv/battery_gauge_reading_conditioner.sv
tb/sv/battery_gauge_reading_conditioner_test.sv
